// ----- src/cdrs_pkg.sv -----
// shared types, codes and control structs of the dependency scoreboard
package cdrs_pkg;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SEL = 2'd1;
	localparam logic [1:0] MODE_CMP = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_OUT  = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] key_id;
		logic        key_is_write;
		logic        last_key;
		logic [5:0]  txn_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] selected_txn;
		logic       all_done;
		logic [6:0] txn_count;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CL_ENT,
		S_CL_CHK,
		S_CL_KEY,
		S_CL_KCMP,
		S_CL_FIN,
		S_SL_IDX,
		S_SL_CHK,
		S_CP_N,
		S_CP_NCHK,
		S_CP_IDX,
		S_CP_CHK,
		S_CP_FIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic cl_init;
		logic idx_clr;
		logic idx_inc;
		logic k_clr;
		logic k_inc;
		logic hit_set;
		logic cl_fin;
		logic sel_init;
		logic sel_wrap;
		logic sel_take;
		logic set_none;
		logic set_bad;
		logic cp_dec;
		logic cp_fin;
		logic rd_n;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic in_add;
		logic in_sel;
		logic in_cmp;
		logic in_close;
		logic in_bad;
		logic idx_end;
		logic skip;
		logic k_last;
		logic key_hit;
		logic wrap_now;
		logic scan_fail;
		logic ready_hit;
		logic phase_out;
		logic dec_ok;
		logic out_free;
	} sts_t;

endpackage

// ----- src/cdrs_ctrl.sv -----
// sequencer state machine of the dependency scoreboard
module cdrs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cdrs_pkg::sts_t sts,
	output cdrs_pkg::cmd_t cmd
);
	import cdrs_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.in_close) state_n = S_CL_ENT;
					else if (sts.in_sel) state_n = S_SL_IDX;
					else if (sts.in_cmp && !sts.in_bad) state_n = S_CP_N;
					else state_n = S_RESP;
				end
			end
			S_CL_ENT:  state_n = sts.idx_end ? S_CL_FIN : S_CL_CHK;
			S_CL_CHK:  state_n = sts.skip ? S_CL_ENT : S_CL_KEY;
			S_CL_KEY:  state_n = S_CL_KCMP;
			S_CL_KCMP: state_n = (sts.key_hit || sts.k_last) ? S_CL_ENT : S_CL_KEY;
			S_CL_FIN:  state_n = S_RESP;
			S_SL_IDX: begin
				if (sts.wrap_now) state_n = S_SL_IDX;
				else if (sts.scan_fail) state_n = S_RESP;
				else state_n = S_SL_CHK;
			end
			S_SL_CHK:  state_n = sts.ready_hit ? S_RESP : S_SL_IDX;
			S_CP_N:    state_n = S_CP_NCHK;
			S_CP_NCHK: state_n = sts.phase_out ? S_CP_IDX : S_RESP;
			S_CP_IDX:  state_n = sts.idx_end ? S_CP_FIN : S_CP_CHK;
			S_CP_CHK:  state_n = S_CP_IDX;
			S_CP_FIN:  state_n = S_RESP;
			S_RESP:    state_n = sts.out_free ? S_IDLE : S_RESP;
			default:   state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					cmd.cl_init  = sts.in_close;
					cmd.idx_clr  = sts.in_close;
					cmd.sel_init = sts.in_sel;
				end
			end
			S_CL_ENT: ;
			S_CL_CHK: begin
				cmd.idx_inc = sts.skip;
				cmd.k_clr   = !sts.skip;
			end
			S_CL_KEY: ;
			S_CL_KCMP: begin
				cmd.hit_set = sts.key_hit;
				cmd.idx_inc = sts.key_hit || sts.k_last;
				cmd.k_inc   = !(sts.key_hit || sts.k_last);
			end
			S_CL_FIN: cmd.cl_fin = 1'b1;
			S_SL_IDX: begin
				cmd.sel_wrap = sts.wrap_now;
				cmd.set_none = !sts.wrap_now && sts.scan_fail;
			end
			S_SL_CHK: begin
				cmd.sel_take = sts.ready_hit;
				cmd.idx_inc  = !sts.ready_hit;
			end
			S_CP_N: cmd.rd_n = 1'b1;
			S_CP_NCHK: begin
				cmd.set_bad = !sts.phase_out;
				cmd.idx_clr = sts.phase_out;
			end
			S_CP_IDX: ;
			S_CP_CHK: begin
				cmd.cp_dec  = sts.dec_ok;
				cmd.idx_inc = 1'b1;
			end
			S_CP_FIN: cmd.cp_fin = 1'b1;
			S_RESP:   cmd.respond = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- src/cdrs_dpath.sv -----
// tables, counters, key compare and result register of the dependency scoreboard
module cdrs_dpath #(
	parameter int MAX_TXNS = 64,
	parameter int MAX_KEYS = 8,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cdrs_pkg::in_word_t  in_data,
	input  cdrs_pkg::cmd_t      cmd,
	output cdrs_pkg::sts_t      sts,
	output logic                out_valid,
	input  logic                out_ready,
	output cdrs_pkg::out_word_t out_data
);
	import cdrs_pkg::*;

	localparam int TW  = $clog2(MAX_TXNS);
	localparam int CW  = $clog2(MAX_TXNS + 1);
	localparam int FW  = $clog2(MAX_KEYS + 1);
	localparam int KIW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int AW  = $clog2(MAX_TXNS * MAX_KEYS);

	logic [KEY_BITS:0]   key_mem [MAX_TXNS*MAX_KEYS];
	logic [FW-1:0]       fill_mem [MAX_TXNS];
	logic [MAX_TXNS-1:0] pred_mem [MAX_TXNS];
	logic [1:0]          ph_mem [MAX_TXNS];
	logic [CW-1:0]       pd_mem [MAX_TXNS];

	logic [KEY_BITS:0]   key_rd_q;
	logic [FW-1:0]       fill_rd_q;
	logic [MAX_TXNS-1:0] pred_rd_q;
	logic [1:0]          ph_rd_q;
	logic [CW-1:0]       pd_rd_q;

	logic [KEY_BITS:0]   cur_key_q [MAX_KEYS];
	logic [FW-1:0]       cur_fill_q;
	logic [CW-1:0]       loaded_q;
	logic [CW-1:0]       handed_q;
	logic [TW-1:0]       scan_q;
	logic [CW-1:0]       idx_q;
	logic [FW-1:0]       k_q;
	logic [CW-1:0]       cnt_q;
	logic [MAX_TXNS-1:0] pred_q;
	logic                wrapped_q;
	logic [TW-1:0]       n_q;
	logic [1:0]          status_q;
	logic [TW-1:0]       sel_q;
	logic                out_valid_q;
	out_word_t           out_q;

	logic [KEY_BITS-1:0] key_v;
	logic                full;
	logic                fill_full;
	logic                key_wr;
	logic [AW-1:0]       key_waddr;
	logic [AW-1:0]       key_raddr;
	logic [TW-1:0]       ent_raddr;
	logic                hit;

	assign key_v     = KEY_BITS'(in_data.key_id);
	assign full      = (loaded_q == CW'(MAX_TXNS));
	assign fill_full = (int'(cur_fill_q) >= MAX_KEYS);
	assign key_wr    = cmd.accept && (in_data.mode == MODE_ADD) && !full && !fill_full;
	assign key_waddr = AW'(int'(loaded_q) * MAX_KEYS + int'(cur_fill_q));
	assign key_raddr = AW'(int'(idx_q[TW-1:0]) * MAX_KEYS + int'(k_q));
	assign ent_raddr = cmd.rd_n ? n_q : idx_q[TW-1:0];

	always_ff @(posedge clk) begin
		if (key_wr) key_mem[key_waddr] <= {in_data.key_is_write, key_v};
		key_rd_q <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cl_fin) begin
			fill_mem[loaded_q[TW-1:0]] <= cur_fill_q;
			pred_mem[loaded_q[TW-1:0]] <= pred_q;
		end
		fill_rd_q <= fill_mem[idx_q[TW-1:0]];
		pred_rd_q <= pred_mem[idx_q[TW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.cl_fin) begin
			ph_mem[loaded_q[TW-1:0]] <= PH_WAIT;
			pd_mem[loaded_q[TW-1:0]] <= cnt_q;
		end else if (cmd.sel_take) begin
			ph_mem[idx_q[TW-1:0]] <= PH_OUT;
		end else if (cmd.cp_dec) begin
			pd_mem[idx_q[TW-1:0]] <= pd_rd_q - CW'(1);
		end else if (cmd.cp_fin) begin
			ph_mem[n_q] <= PH_DONE;
		end
		ph_rd_q <= ph_mem[ent_raddr];
		pd_rd_q <= pd_mem[ent_raddr];
	end

	always_comb begin
		hit = 1'b0;
		for (int m = 0; m < MAX_KEYS; m++) begin
			if ((m < int'(cur_fill_q)) &&
			    (cur_key_q[m][KEY_BITS-1:0] == key_rd_q[KEY_BITS-1:0]) &&
			    (cur_key_q[m][KEY_BITS] || key_rd_q[KEY_BITS])) hit = 1'b1;
		end
	end

	always_comb begin
		sts           = '0;
		sts.in_add    = (in_data.mode == MODE_ADD);
		sts.in_sel    = (in_data.mode == MODE_SEL);
		sts.in_cmp    = (in_data.mode == MODE_CMP);
		sts.in_close  = sts.in_add && !full && in_data.last_key;
		sts.in_bad    = sts.in_cmp && (32'(in_data.txn_index) >= 32'(loaded_q));
		sts.idx_end   = (idx_q == loaded_q);
		sts.skip      = (ph_rd_q == PH_DONE) || (fill_rd_q == '0);
		sts.k_last    = (int'(k_q) + 1 >= int'(fill_rd_q));
		sts.key_hit   = hit;
		sts.wrap_now  = !wrapped_q && (idx_q >= loaded_q);
		sts.scan_fail = wrapped_q && ((idx_q >= CW'(scan_q)) || (idx_q >= loaded_q));
		sts.ready_hit = (ph_rd_q == PH_WAIT) && (pd_rd_q == '0);
		sts.phase_out = (ph_rd_q == PH_OUT);
		sts.dec_ok    = pred_rd_q[n_q] && (pd_rd_q != '0);
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_fill_q  <= '0;
			loaded_q    <= '0;
			handed_q    <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_wr) cur_fill_q <= cur_fill_q + FW'(1);
			if (cmd.cl_fin) begin
				cur_fill_q <= '0;
				loaded_q   <= loaded_q + CW'(1);
			end
			if (cmd.sel_take) begin
				handed_q <= handed_q + CW'(1);
				if (wrapped_q) scan_q <= idx_q[TW-1:0];
			end
			if (cmd.respond) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (key_wr) cur_key_q[cur_fill_q[KIW-1:0]] <= {in_data.key_is_write, key_v};
		if (cmd.accept) begin
			n_q   <= TW'(in_data.txn_index);
			sel_q <= '0;
			unique case (in_data.mode)
				MODE_ADD: status_q <= (full || fill_full) ? ST_OVF : ST_OK;
				MODE_CMP: status_q <= sts.in_bad ? ST_BAD : ST_OK;
				default:  status_q <= ST_OK;
			endcase
		end
		if (cmd.set_none) status_q <= ST_NONE;
		if (cmd.set_bad) status_q <= ST_BAD;
		if (cmd.cl_init) begin
			cnt_q  <= '0;
			pred_q <= '0;
		end
		if (cmd.hit_set) begin
			cnt_q <= cnt_q + CW'(1);
			pred_q[idx_q[TW-1:0]] <= 1'b1;
		end
		if (cmd.idx_clr) idx_q <= '0;
		else if (cmd.idx_inc) idx_q <= idx_q + CW'(1);
		else if (cmd.sel_init) idx_q <= CW'(scan_q);
		else if (cmd.sel_wrap) idx_q <= '0;
		if (cmd.sel_init) wrapped_q <= 1'b0;
		else if (cmd.sel_wrap) wrapped_q <= 1'b1;
		if (cmd.k_clr) k_q <= '0;
		else if (cmd.k_inc) k_q <= k_q + FW'(1);
		if (cmd.sel_take) sel_q <= idx_q[TW-1:0];
		if (cmd.respond) begin
			out_q.status       <= status_q;
			out_q.selected_txn <= 6'(sel_q);
			out_q.all_done     <= (handed_q == loaded_q);
			out_q.txn_count    <= 7'(loaded_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/conflict_dag_ready_scheduler.sv -----
// top level of the transaction dependency scoreboard
// channel  | signals                      | word
// input    | in_valid, in_ready, in_data  | mode, key_id, key_is_write, last_key, txn_index
// output   | out_valid, out_ready, out_data | status, selected_txn, all_done, txn_count
// one word at a time; add key without close goes straight to the result hand-off
// close of txn t: scans each earlier txn not done, comparing its stored keys until a hit, key port bound
// select: scans entries from the scan start, wrapping once; complete: reads txn n, then scans all txn_count entries
// reset clears the fill, load and hand-out counters and control; no clearing pass, tables are written before read
// a stalled result holds the block in its answer state until out_ready
module conflict_dag_ready_scheduler #(
	parameter int MAX_TXNS = 64,
	parameter int MAX_KEYS = 8,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdrs_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cdrs_pkg::out_word_t out_data
);
	import cdrs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cdrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdrs_dpath #(
		.MAX_TXNS (MAX_TXNS),
		.MAX_KEYS (MAX_KEYS),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- src/cdrs_checker.sv -----
// port-level assertions of the dependency scoreboard and their bind
module cdrs_checker #(
	parameter int MAX_TXNS = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input cdrs_pkg::out_word_t out_data
);
	import cdrs_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_data.txn_count) <= MAX_TXNS))
		else $error("txn count out of range");

	a_none_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status != ST_OK)) |-> (out_data.selected_txn == 6'd0))
		else $error("selection reported on failure");

endmodule

bind conflict_dag_ready_scheduler cdrs_checker #(.MAX_TXNS(MAX_TXNS)) u_cdrs_checker (.*);
